// ===== rtl/sfpf_pkg.sv =====
// Package for the SYN flood packet filter.
// Holds the table sizes, reason codes, controller states and the
// command and status structures shared by all modules.
package sfpf_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int COUNT_BITS    = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int IN_DATA_BITS  = 152;
    localparam int OUT_DATA_BITS = 8;

    localparam logic [1:0] CFG_TRUSTED_HOST = 2'd0;
    localparam logic [1:0] CFG_EXEMPT_PORT  = 2'd1;
    localparam logic [1:0] CFG_SYN_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_TOTAL_LIMIT  = 2'd3;

    localparam logic [31:0] RST_TRUSTED_HOST = 32'hC0A8_1501;
    localparam logic [15:0] RST_EXEMPT_PORT  = 16'd22;
    localparam logic [7:0]  RST_SYN_LIMIT    = 8'd10;
    localparam logic [7:0]  RST_TOTAL_LIMIT  = 8'd100;

    localparam logic [15:0] MIN_IP_LEN = 16'd20;

    localparam logic [3:0] REASON_NORMAL    = 4'd0;
    localparam logic [3:0] REASON_SHORTIP   = 4'd1;
    localparam logic [3:0] REASON_SHORTTCP  = 4'd2;
    localparam logic [3:0] REASON_TRUSTED   = 4'd3;
    localparam logic [3:0] REASON_PORT      = 4'd4;
    localparam logic [3:0] REASON_BLACK     = 4'd5;
    localparam logic [3:0] REASON_LIMIT     = 4'd6;
    localparam logic [3:0] REASON_WHITE     = 4'd7;
    localparam logic [3:0] REASON_PROMOTED  = 4'd8;
    localparam logic [3:0] REASON_FIRSTDROP = 4'd9;
    localparam logic [3:0] REASON_TICK      = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic early_commit;
        logic scan_init;
        logic scan_step;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic scan_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [31:0]           key;
        logic [COUNT_BITS-1:0] total;
        logic [COUNT_BITS-1:0] syns;
    } cnt_entry_t;

endpackage

// ===== rtl/sfpf_ctrl.sv =====
// Controller state machine of the SYN flood packet filter.
// Depends on sfpf_pkg; drives the datapath through command signals.
module sfpf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  sfpf_pkg::status_t status,
    output sfpf_pkg::cmd_t   cmd
);
    import sfpf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.early)
                begin
                    cmd.early_commit = 1'b1;
                    state_next       = ST_OUT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sfpf_datapath.sv =====
// Datapath of the SYN flood packet filter: configuration registers, the
// four address tables with their valid bits, the scan compare and the verdict.
// Depends on sfpf_pkg; steered by sfpf_ctrl.
module sfpf_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sfpf_pkg::cmd_t                     cmd,
    output sfpf_pkg::status_t                  status,
    input  logic                               cfg_write,
    input  logic [1:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_req_type,
    input  logic [sfpf_pkg::IN_DATA_BITS-1:0]  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sfpf_pkg::OUT_DATA_BITS-1:0] out_data
);
    import sfpf_pkg::*;

    logic [31:0] trusted_reg;
    logic [15:0] exempt_reg;
    logic [7:0]  syn_limit_reg;
    logic [7:0]  total_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trusted_reg     <= RST_TRUSTED_HOST;
            exempt_reg      <= RST_EXEMPT_PORT;
            syn_limit_reg   <= RST_SYN_LIMIT;
            total_limit_reg <= RST_TOTAL_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TRUSTED_HOST: trusted_reg     <= cfg_data;
                CFG_EXEMPT_PORT:  exempt_reg      <= cfg_data[15:0];
                CFG_SYN_LIMIT:    syn_limit_reg   <= cfg_data[7:0];
                CFG_TOTAL_LIMIT:  total_limit_reg <= cfg_data[7:0];
                default:          trusted_reg     <= trusted_reg;
            endcase
        end
    end

    logic        req_reg;
    logic [31:0] src_reg;
    logic [3:0]  ihw_reg;
    logic [15:0] plen_reg;
    logic [15:0] sport_reg;
    logic [15:0] dport_reg;
    logic        syn_reg;
    logic [31:0] gsyn_reg;
    logic [31:0] gack_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= in_req_type;
            src_reg   <= in_data[31:0];
            ihw_reg   <= in_data[35:32];
            plen_reg  <= in_data[51:36];
            sport_reg <= in_data[67:52];
            dport_reg <= in_data[83:68];
            syn_reg   <= in_data[84];
            gsyn_reg  <= in_data[116:85];
            gack_reg  <= in_data[148:117];
        end
    end

    logic [15:0] tcp_min_len;
    logic        early;
    logic        early_drop;
    logic [3:0]  early_reason;
    logic [35:0] ack_times_ten;
    logic        emerg_trip;

    assign tcp_min_len   = {10'd0, ihw_reg, 2'b00} + MIN_IP_LEN;
    assign ack_times_ten = {1'b0, gack_reg, 3'b000} + {3'b000, gack_reg, 1'b0};
    assign emerg_trip    = ack_times_ten < {4'd0, gsyn_reg};

    always_comb
    begin
        early        = 1'b1;
        early_drop   = 1'b0;
        early_reason = REASON_NORMAL;
        if (req_reg)
        begin
            early_reason = REASON_TICK;
        end
        else if (plen_reg < MIN_IP_LEN)
        begin
            early_reason = REASON_SHORTIP;
        end
        else if (tcp_min_len > plen_reg)
        begin
            early_drop   = 1'b1;
            early_reason = REASON_SHORTTCP;
        end
        else if (src_reg == trusted_reg)
        begin
            early_reason = REASON_TRUSTED;
        end
        else if (dport_reg == exempt_reg || sport_reg == exempt_reg)
        begin
            early_reason = REASON_PORT;
        end
        else
        begin
            early = 1'b0;
        end
    end

    cnt_entry_t  cnt_mem [TABLE_ENTRIES];
    logic [31:0] blk_mem [TABLE_ENTRIES];
    logic [31:0] wht_mem [TABLE_ENTRIES];
    logic [31:0] gry_mem [TABLE_ENTRIES];

    logic [TABLE_ENTRIES-1:0] cnt_valid_reg;
    logic [TABLE_ENTRIES-1:0] blk_valid_reg;
    logic [TABLE_ENTRIES-1:0] wht_valid_reg;
    logic [TABLE_ENTRIES-1:0] gry_valid_reg;

    logic [IDX_BITS-1:0] idx_reg;
    logic [IDX_BITS-1:0] idx_d_reg;
    logic                cmp_en_reg;
    cnt_entry_t          cnt_rd_reg;
    logic [31:0]         blk_rd_reg;
    logic [31:0]         wht_rd_reg;
    logic [31:0]         gry_rd_reg;

    always_ff @(posedge clk)
    begin
        cnt_rd_reg <= cnt_mem[idx_reg];
        blk_rd_reg <= blk_mem[idx_reg];
        wht_rd_reg <= wht_mem[idx_reg];
        gry_rd_reg <= gry_mem[idx_reg];
        idx_d_reg  <= idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_step;
            if (cmd.scan_init)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    logic                  cnt_hit_reg;
    logic [IDX_BITS-1:0]   cnt_slot_reg;
    logic [COUNT_BITS-1:0] cnt_total_reg;
    logic [COUNT_BITS-1:0] cnt_syns_reg;
    logic                  cnt_free_ok_reg;
    logic [IDX_BITS-1:0]   cnt_free_reg;
    logic                  blk_hit_reg;
    logic                  blk_free_ok_reg;
    logic [IDX_BITS-1:0]   blk_free_reg;
    logic                  wht_hit_reg;
    logic                  wht_free_ok_reg;
    logic [IDX_BITS-1:0]   wht_free_reg;
    logic                  gry_hit_reg;
    logic [IDX_BITS-1:0]   gry_slot_reg;
    logic                  gry_free_ok_reg;
    logic [IDX_BITS-1:0]   gry_free_reg;

    logic cv;
    logic bv;
    logic wv;
    logic gv;

    assign cv = cnt_valid_reg[idx_d_reg];
    assign bv = blk_valid_reg[idx_d_reg];
    assign wv = wht_valid_reg[idx_d_reg];
    assign gv = gry_valid_reg[idx_d_reg];

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            cnt_hit_reg     <= 1'b0;
            cnt_free_ok_reg <= 1'b0;
            blk_hit_reg     <= 1'b0;
            blk_free_ok_reg <= 1'b0;
            wht_hit_reg     <= 1'b0;
            wht_free_ok_reg <= 1'b0;
            gry_hit_reg     <= 1'b0;
            gry_free_ok_reg <= 1'b0;
        end
        else if (cmp_en_reg)
        begin
            if (cv && cnt_rd_reg.key == src_reg && !cnt_hit_reg)
            begin
                cnt_hit_reg   <= 1'b1;
                cnt_slot_reg  <= idx_d_reg;
                cnt_total_reg <= cnt_rd_reg.total;
                cnt_syns_reg  <= cnt_rd_reg.syns;
            end
            if (!cv && !cnt_free_ok_reg)
            begin
                cnt_free_ok_reg <= 1'b1;
                cnt_free_reg    <= idx_d_reg;
            end
            if (bv && blk_rd_reg == src_reg)
            begin
                blk_hit_reg <= 1'b1;
            end
            if (!bv && !blk_free_ok_reg)
            begin
                blk_free_ok_reg <= 1'b1;
                blk_free_reg    <= idx_d_reg;
            end
            if (wv && wht_rd_reg == src_reg)
            begin
                wht_hit_reg <= 1'b1;
            end
            if (!wv && !wht_free_ok_reg)
            begin
                wht_free_ok_reg <= 1'b1;
                wht_free_reg    <= idx_d_reg;
            end
            if (gv && gry_rd_reg == src_reg && !gry_hit_reg)
            begin
                gry_hit_reg  <= 1'b1;
                gry_slot_reg <= idx_d_reg;
            end
            if (!gv && !gry_free_ok_reg)
            begin
                gry_free_ok_reg <= 1'b1;
                gry_free_reg    <= idx_d_reg;
            end
        end
    end

    logic                  emerg_reg;
    logic                  cnt_ok;
    logic [IDX_BITS-1:0]   cnt_sel;
    logic [COUNT_BITS-1:0] base_total;
    logic [COUNT_BITS-1:0] base_syns;
    logic [COUNT_BITS-1:0] new_total;
    logic [COUNT_BITS-1:0] new_syns;
    logic                  over_limit;
    logic                  blk_ins;
    logic                  wht_ins;
    logic                  gry_ins;
    logic                  gry_del;
    logic                  upd_drop;
    logic [3:0]            upd_reason;
    logic                  upd_badd;
    logic                  upd_full;

    assign cnt_ok     = cnt_hit_reg || cnt_free_ok_reg;
    assign cnt_sel    = cnt_hit_reg ? cnt_slot_reg : cnt_free_reg;
    assign base_total = cnt_hit_reg ? cnt_total_reg : '0;
    assign base_syns  = cnt_hit_reg ? cnt_syns_reg : '0;
    assign new_total  = (base_total == COUNT_MAX) ? base_total : base_total + 1'b1;
    assign new_syns   = (syn_reg && base_syns != COUNT_MAX) ? base_syns + 1'b1 : base_syns;
    assign over_limit = cnt_ok && (33'(new_syns) > 33'(syn_limit_reg) ||
                                   33'(new_total) > 33'(total_limit_reg));

    always_comb
    begin
        blk_ins    = 1'b0;
        wht_ins    = 1'b0;
        gry_ins    = 1'b0;
        gry_del    = 1'b0;
        upd_drop   = 1'b0;
        upd_reason = REASON_NORMAL;
        upd_badd   = 1'b0;
        upd_full   = !cnt_ok;
        if (blk_hit_reg)
        begin
            upd_drop   = 1'b1;
            upd_reason = REASON_BLACK;
        end
        else if (over_limit)
        begin
            upd_drop   = 1'b1;
            upd_reason = REASON_LIMIT;
            if (blk_free_ok_reg)
            begin
                blk_ins  = 1'b1;
                upd_badd = 1'b1;
            end
            else
            begin
                upd_full = 1'b1;
            end
        end
        else if (emerg_reg && syn_reg)
        begin
            if (wht_hit_reg)
            begin
                upd_reason = REASON_WHITE;
            end
            else if (gry_hit_reg)
            begin
                gry_del    = 1'b1;
                upd_reason = REASON_PROMOTED;
                if (wht_free_ok_reg)
                begin
                    wht_ins = 1'b1;
                end
                else
                begin
                    upd_full = 1'b1;
                end
            end
            else
            begin
                upd_drop   = 1'b1;
                upd_reason = REASON_FIRSTDROP;
                if (gry_free_ok_reg)
                begin
                    gry_ins = 1'b1;
                end
                else
                begin
                    upd_full = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (cnt_ok)
            begin
                cnt_mem[cnt_sel] <= '{key: src_reg, total: new_total, syns: new_syns};
            end
            if (blk_ins)
            begin
                blk_mem[blk_free_reg] <= src_reg;
            end
            if (wht_ins)
            begin
                wht_mem[wht_free_reg] <= src_reg;
            end
            if (gry_ins)
            begin
                gry_mem[gry_free_reg] <= src_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
            blk_valid_reg <= '0;
            wht_valid_reg <= '0;
            gry_valid_reg <= '0;
            emerg_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.early_commit && req_reg)
            begin
                cnt_valid_reg <= '0;
            end
            if (cmd.scan_init && emerg_trip)
            begin
                emerg_reg <= 1'b1;
            end
            if (cmd.update)
            begin
                if (cnt_ok)
                begin
                    cnt_valid_reg[cnt_sel] <= 1'b1;
                end
                if (blk_ins)
                begin
                    blk_valid_reg[blk_free_reg] <= 1'b1;
                end
                if (wht_ins)
                begin
                    wht_valid_reg[wht_free_reg] <= 1'b1;
                end
                if (gry_del)
                begin
                    gry_valid_reg[gry_slot_reg] <= 1'b0;
                end
                if (gry_ins)
                begin
                    gry_valid_reg[gry_free_reg] <= 1'b1;
                end
            end
        end
    end

    logic [OUT_DATA_BITS-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.early_commit)
        begin
            res_reg <= {1'b0, emerg_reg, 1'b0, early_reason, early_drop};
        end
        else if (cmd.update)
        begin
            res_reg <= {upd_full, emerg_reg, upd_badd, upd_reason, upd_drop};
        end
    end

    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.early     = early;
    assign status.scan_last = (idx_reg == IDX_BITS'(TABLE_ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

// ===== rtl/syn_flood_packet_filter.sv =====
// Top level of the SYN flood packet filter.
// Depends on sfpf_pkg, sfpf_ctrl and sfpf_datapath.
//
// Each packet or tick transfer on the slave stream yields exactly one verdict
// transfer on the master stream. A tick (tuser high) clears the per-source
// counters. Packets that are short, from the trusted host or on the exempt
// port are decided from the check state without a table search; all other
// packets search the counter, blacklist, whitelist and greylist tables in
// one pass, one entry of each per cycle, then pass the flush and update
// states before the verdict is loaded. One item is worked on at a time;
// s_axis_tready is high only while the block waits for an item.
// The verdict sits in an output register, so a stalled receiver holds only
// the next verdict back; the block keeps its result until m_axis_tready.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// should be made while no item is in flight.
// Reset clears all table valid bits, the emergency latch and restores the
// register defaults; no clearing pass is needed.
module syn_flood_packet_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // src_ip, ip_header_words, packet_len, src_port, dst_port, syn_flag,
    // global_syn_count, global_ack_count, zero padding
    input  logic [sfpf_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // drop, reason, blacklist_add, emergency_active, table_full
    output logic [sfpf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [31:0]                        cfg_data
);
    import sfpf_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sfpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfpf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_req_type (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

// ===== rtl/sfpf_checker.sv =====
// Port checker for the SYN flood packet filter, bound to the top level.
// Depends on sfpf_pkg.
module sfpf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [sfpf_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import sfpf_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled verdict changed.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Second item taken while one is in flight.");

    a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:1] == REASON_TICK
        |-> !m_axis_tdata[0] && !m_axis_tdata[5] && !m_axis_tdata[7])
        else $error("Tick verdict carries a drop or a flag.");

    a_badd_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5]
        |-> m_axis_tdata[0] && m_axis_tdata[4:1] == REASON_LIMIT)
        else $error("Blacklist export without a limit drop.");

    a_shortip_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4:1] == REASON_SHORTIP |-> !m_axis_tdata[0])
        else $error("Short IP packet dropped.");

endmodule

bind syn_flood_packet_filter sfpf_checker u_sfpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/syn_flood_packet_filter_tb.sv =====
// Self-checking testbench for the SYN flood packet filter.
// Depends on sfpf_pkg and the syn_flood_packet_filter RTL; it predicts every
// verdict with its own table model held in a small scoreboard class.
`timescale 1ns / 100ps

module syn_flood_packet_filter_tb;
    import sfpf_pkg::*;

    typedef struct {
        logic        tick;
        logic [31:0] src_ip;
        logic [3:0]  hdr_words;
        logic [15:0] pkt_len;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        syn;
        logic [31:0] glob_syn;
        logic [31:0] glob_ack;
    } pkt_t;

    class verdict_board;
        logic [31:0] cnt_key [TABLE_ENTRIES];
        logic [COUNT_BITS-1:0] cnt_total [TABLE_ENTRIES];
        logic [COUNT_BITS-1:0] cnt_syns [TABLE_ENTRIES];
        bit          cnt_ok [TABLE_ENTRIES];
        logic [31:0] black_key [TABLE_ENTRIES];
        bit          black_ok [TABLE_ENTRIES];
        logic [31:0] white_key [TABLE_ENTRIES];
        bit          white_ok [TABLE_ENTRIES];
        logic [31:0] grey_key [TABLE_ENTRIES];
        bit          grey_ok [TABLE_ENTRIES];
        bit          emergency;
        logic [31:0] trusted_ip;
        logic [15:0] exempt;
        logic [7:0]  syn_lim;
        logic [7:0]  total_lim;
        logic [7:0]  verdicts [$];
        int          errors;

        function new();
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                cnt_ok[i] = 0;
                black_ok[i] = 0;
                white_ok[i] = 0;
                grey_ok[i] = 0;
            end
            emergency = 0;
            trusted_ip = RST_TRUSTED_HOST;
            exempt = RST_EXEMPT_PORT;
            syn_lim = RST_SYN_LIMIT;
            total_lim = RST_TOTAL_LIMIT;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_TRUSTED_HOST: trusted_ip = val;
                CFG_EXEMPT_PORT:  exempt = val[15:0];
                CFG_SYN_LIMIT:    syn_lim = val[7:0];
                CFG_TOTAL_LIMIT:  total_lim = val[7:0];
            endcase
        endfunction

        function int find_addr(ref bit ok [TABLE_ENTRIES], ref logic [31:0] k [TABLE_ENTRIES],
                               input logic [31:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (ok[i] && k[i] == key)
                    return i;
            return -1;
        endfunction

        function bit add_addr(ref bit ok [TABLE_ENTRIES], ref logic [31:0] k [TABLE_ENTRIES],
                              input logic [31:0] key);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!ok[i])
                begin
                    ok[i] = 1;
                    k[i] = key;
                    return 1;
                end
            return 0;
        endfunction

        function int count_source(logic [31:0] key, logic syn);
            int slot;
            slot = find_addr(cnt_ok, cnt_key, key);
            if (slot < 0)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!cnt_ok[i])
                    begin
                        slot = i;
                        cnt_ok[i] = 1;
                        cnt_key[i] = key;
                        cnt_total[i] = '0;
                        cnt_syns[i] = '0;
                        break;
                    end
                if (slot < 0)
                    return -1;
            end
            if (cnt_total[slot] != COUNT_MAX)
                cnt_total[slot]++;
            if (syn && cnt_syns[slot] != COUNT_MAX)
                cnt_syns[slot]++;
            return slot;
        endfunction

        function void note_packet(pkt_t p);
            logic       drop, badd, full;
            logic [3:0] why;
            logic [35:0] ack10;
            int         slot, g;
            drop = 0;
            badd = 0;
            full = 0;
            why = REASON_NORMAL;
            ack10 = 36'(p.glob_ack) * 36'd10;
            if (p.tick)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    cnt_ok[i] = 0;
                why = REASON_TICK;
            end
            else if (p.pkt_len < MIN_IP_LEN)
                why = REASON_SHORTIP;
            else if (18'(p.hdr_words) * 18'd4 + 18'd20 > 18'(p.pkt_len))
            begin
                drop = 1;
                why = REASON_SHORTTCP;
            end
            else if (p.src_ip == trusted_ip)
                why = REASON_TRUSTED;
            else if (p.dst_port == exempt || p.src_port == exempt)
                why = REASON_PORT;
            else
            begin
                if (ack10 < 36'(p.glob_syn))
                    emergency = 1;
                slot = count_source(p.src_ip, p.syn);
                if (slot < 0)
                    full = 1;
                if (find_addr(black_ok, black_key, p.src_ip) >= 0)
                begin
                    drop = 1;
                    why = REASON_BLACK;
                end
                else if (slot >= 0 && (cnt_syns[slot] > syn_lim || cnt_total[slot] > total_lim))
                begin
                    if (add_addr(black_ok, black_key, p.src_ip))
                        badd = 1;
                    else
                        full = 1;
                    drop = 1;
                    why = REASON_LIMIT;
                end
                else if (emergency && p.syn)
                begin
                    if (find_addr(white_ok, white_key, p.src_ip) >= 0)
                        why = REASON_WHITE;
                    else
                    begin
                        g = find_addr(grey_ok, grey_key, p.src_ip);
                        if (g >= 0)
                        begin
                            grey_ok[g] = 0;
                            if (!add_addr(white_ok, white_key, p.src_ip))
                                full = 1;
                            why = REASON_PROMOTED;
                        end
                        else
                        begin
                            if (!add_addr(grey_ok, grey_key, p.src_ip))
                                full = 1;
                            drop = 1;
                            why = REASON_FIRSTDROP;
                        end
                    end
                end
            end
            verdicts.insert(verdicts.size(), {full, emergency, badd, why, drop});
        endfunction

        function void compare(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_verdict(logic [7:0] act);
            logic [7:0] exp_v;
            if (verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict transfer, actual %h", $time, act);
                errors++;
                return;
            end
            exp_v = verdicts.pop_front();
            compare("drop", exp_v[0], act[0]);
            compare("reason", exp_v[4:1], act[4:1]);
            compare("blacklist_add", exp_v[5], act[5]);
            compare("emergency_active", exp_v[6], act[6]);
            compare("table_full", exp_v[7], act[7]);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = '0;
    logic [31:0]              cfg_data = '0;

    verdict_board sb = new();
    int  send_idle_pct = 32;
    int  recv_idle_pct = 85;
    int  hold_cycles = 0;
    bit  emerg_ok = 0;
    int  limits_mode = 0;
    logic [31:0] hot_src;

    syn_flood_packet_filter dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_verdict(m_axis_tdata);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_packet(pkt_t p);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= p.tick;
        s_axis_tdata <= {3'b0, p.glob_ack, p.glob_syn, p.syn, p.dst_port, p.src_port,
                         p.pkt_len, p.hdr_words, p.src_ip};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_packet(p);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.verdicts.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic pkt_t base_packet(logic [31:0] src, logic syn);
        pkt_t p;
        p.tick = 0;
        p.src_ip = src;
        p.hdr_words = 4'd5;
        p.pkt_len = 16'd60;
        p.src_port = 16'd40000;
        p.dst_port = 16'd80;
        p.syn = syn;
        p.glob_syn = 32'd0;
        p.glob_ack = 32'd0;
        return p;
    endfunction

    function automatic pkt_t random_packet();
        pkt_t p;
        int   r;
        logic [17:0] need;
        r = $urandom_range(0, 99);
        if (r < 10)
            p.src_ip = $urandom;
        else if (r < 35)
            p.src_ip = hot_src;
        else
            p.src_ip = 32'h0A00_0000 + $urandom_range(0, 95);
        p.tick = ($urandom_range(0, 99) < 3);
        p.hdr_words = 4'($urandom);
        need = 18'(p.hdr_words) * 18'd4 + 18'd20;
        r = $urandom_range(0, 99);
        if (r < 5)
            p.pkt_len = 16'($urandom_range(0, 19));
        else if (r < 10)
            p.pkt_len = 16'($urandom_range(20, 79));
        else if (r < 15)
            p.pkt_len = 16'($urandom);
        else
            p.pkt_len = 16'($urandom_range(need[15:0], 16'hFFFF));
        p.src_port = 16'($urandom);
        p.dst_port = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 4)
            p.src_ip = sb.trusted_ip;
        else if (r < 7)
            p.dst_port = sb.exempt;
        else if (r < 10)
            p.src_port = sb.exempt;
        p.syn = ($urandom_range(0, 99) < 70);
        p.glob_ack = $urandom;
        p.glob_syn = $urandom;
        if (!emerg_ok && 36'(p.glob_ack) * 10 < 36'(p.glob_syn))
            p.glob_syn = p.glob_ack;
        return p;
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                hot_src = 32'h0A00_0000 + $urandom_range(0, 95);
            send_packet(random_packet());
        end
    endtask

    initial
    begin
        pkt_t p;
        hot_src = 32'h0A00_0001;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_reg(CFG_SYN_LIMIT, 32'd255);
        write_reg(CFG_TOTAL_LIMIT, 32'd255);

        p = base_packet(32'h0, 1'b0);
        p.tick = 1;
        send_packet(p);
        p = base_packet(32'hFFFF_FFFF, 1'b1);
        p.pkt_len = 16'd0;
        send_packet(p);
        p.pkt_len = 16'd19;
        send_packet(p);
        p.hdr_words = 4'd0;
        p.pkt_len = 16'd20;
        send_packet(p);
        p.hdr_words = 4'd15;
        p.pkt_len = 16'd79;
        send_packet(p);
        p.pkt_len = 16'd80;
        send_packet(p);
        p.pkt_len = 16'hFFFF;
        p.src_port = 16'hFFFF;
        p.dst_port = 16'h0;
        send_packet(p);
        p = base_packet(RST_TRUSTED_HOST, 1'b1);
        send_packet(p);
        p = base_packet(32'h0A00_0001, 1'b1);
        p.dst_port = RST_EXEMPT_PORT;
        send_packet(p);
        p.dst_port = 16'd80;
        p.src_port = RST_EXEMPT_PORT;
        send_packet(p);
        p = base_packet(32'h0A00_0002, 1'b1);
        p.glob_syn = 32'd10;
        p.glob_ack = 32'd1;
        send_packet(p);
        p.glob_syn = 32'hFFFF_FFFF;
        p.glob_ack = 32'hFFFF_FFFF;
        send_packet(p);

        // Counter saturation: one source far beyond the count range.
        p = base_packet(32'h0B00_0007, 1'b1);
        for (int i = 0; i < 260; i++)
            send_packet(p);
        random_run(200);
        drain();

        send_idle_pct = 85;
        recv_idle_pct = 32;
        write_reg(CFG_TRUSTED_HOST, 32'h0);
        write_reg(CFG_EXEMPT_PORT, 32'hFFFF);
        emerg_ok = 1;
        p = base_packet(32'h0A00_0003, 1'b1);
        p.glob_syn = 32'd11;
        p.glob_ack = 32'd1;
        send_packet(p);
        // Two SYNs per source, then a third, to move sources grey, white and on.
        for (int i = 0; i < 90; i++)
        begin
            p = base_packet(32'h0C00_0000 + i, 1'b1);
            send_packet(p);
            send_packet(p);
            send_packet(p);
        end
        random_run(130);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_TRUSTED_HOST, 32'hFFFF_FFFF);
        write_reg(CFG_EXEMPT_PORT, 32'h0);
        write_reg(CFG_SYN_LIMIT, 32'd0);
        write_reg(CFG_TOTAL_LIMIT, 32'd0);
        random_run(300);
        drain();

        send_idle_pct = 0;
        write_reg(CFG_TRUSTED_HOST, $urandom);
        write_reg(CFG_EXEMPT_PORT, 32'd22);
        write_reg(CFG_SYN_LIMIT, 32'd10);
        write_reg(CFG_TOTAL_LIMIT, 32'd100);
        hold_cycles = 600;
        random_run(250);
        drain();

        if (sb.errors == 0 && sb.verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== syn_flood_packet_filter.f =====
rtl/sfpf_pkg.sv
rtl/sfpf_ctrl.sv
rtl/sfpf_datapath.sv
rtl/syn_flood_packet_filter.sv
rtl/sfpf_checker.sv
tb/syn_flood_packet_filter_tb.sv
